### rtl/core/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, branch codes and the square-root side-band type of the
// rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;  // matrix element and component width
    localparam int T_W           = 18;  // three-term diagonal combinations
    localparam int N_W           = 18;  // off-diagonal sums and differences
    localparam int MAG_W         = 17;  // magnitude of an off-diagonal term

    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    typedef struct packed {
        t_branch               sel;
        logic signed [N_W-1:0] n0;
        logic signed [N_W-1:0] n1;
        logic signed [N_W-1:0] n2;
    } t_sq_side;

endpackage

### rtl/core/rmq_isqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_isqrt_pipe
// Fully pipelined integer square root, one result bit per stage, with a
// side-band word carried along each transaction.
// ----------------------------------------------------------------------------
module rmq_isqrt_pipe #(
    parameter int RAD_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [RAD_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int STAGES = RAD_W / 2;

    logic              r_vld  [STAGES];
    logic [RAD_W-1:0]  r_x    [STAGES];
    logic [RAD_W-1:0]  r_res  [STAGES];
    logic [SIDE_W-1:0] r_side [STAGES];

    logic              n_vld  [STAGES];
    logic [RAD_W-1:0]  n_x    [STAGES];
    logic [RAD_W-1:0]  n_res  [STAGES];
    logic [SIDE_W-1:0] n_side [STAGES];

    always_comb begin
        logic [RAD_W-1:0] x_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W:0]   bit_v;
        logic [RAD_W:0]   trial;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                n_vld[s]  = i_valid;
                n_side[s] = i_side;
                x_in      = i_rad;
                res_in    = '0;
            end else begin
                n_vld[s]  = r_vld[s-1];
                n_side[s] = r_side[s-1];
                x_in      = r_x[s-1];
                res_in    = r_res[s-1];
            end
            bit_v = (RAD_W+1)'(1) << (2 * (STAGES - 1 - s));
            trial = {1'b0, res_in} + bit_v;
            if ({1'b0, x_in} >= trial) begin
                n_x[s]   = x_in - trial[RAD_W-1:0];
                n_res[s] = (res_in >> 1) + bit_v[RAD_W-1:0];
            end else begin
                n_x[s]   = x_in;
                n_res[s] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STAGES; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STAGES; s++) begin
            r_x[s]    <= n_x[s];
            r_res[s]  <= n_res[s];
            r_side[s] <= n_side[s];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_res[STAGES-1][STAGES-1:0];
    assign o_side  = r_side[STAGES-1];

endmodule

### rtl/core/rmq_div3_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div3_pipe
// Three restoring dividers sharing one divisor, an entry stage, then one quotient bit per stage,
// with an overflow flag for quotients that do not fit and a side-band word.
// ----------------------------------------------------------------------------
module rmq_div3_pipe #(
    parameter int A_W    = 31,
    parameter int D_W    = 17,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [2:0][A_W-1:0]       i_num,
    input  logic [D_W-1:0]            i_den,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [2:0][Q_W-1:0]       o_quo,
    output logic [2:0]                o_ovf,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int CW     = (A_W > D_W + Q_W) ? A_W : D_W + Q_W;
    localparam int STAGES = Q_W + 1;

    logic                r_vld  [STAGES];
    logic [2:0][A_W-1:0] r_rem  [STAGES];
    logic [2:0][Q_W-1:0] r_q    [STAGES];
    logic [2:0]          r_ovf  [STAGES];
    logic [D_W-1:0]      r_den  [STAGES];
    logic [SIDE_W-1:0]   r_side [STAGES];

    logic                n_vld  [STAGES];
    logic [2:0][A_W-1:0] n_rem  [STAGES];
    logic [2:0][Q_W-1:0] n_q    [STAGES];
    logic [2:0]          n_ovf  [STAGES];
    logic [D_W-1:0]      n_den  [STAGES];
    logic [SIDE_W-1:0]   n_side [STAGES];

    always_comb begin
        logic [CW-1:0] sub;
        // entry: flag quotients that need more than Q_W bits
        n_vld[0]  = i_valid;
        n_den[0]  = i_den;
        n_side[0] = i_side;
        for (int k = 0; k < 3; k++) begin
            n_rem[0][k] = i_num[k];
            n_q[0][k]   = '0;
            n_ovf[0][k] = CW'(i_num[k]) >= (CW'(i_den) << Q_W);
        end
        for (int j = 1; j < STAGES; j++) begin
            n_vld[j]  = r_vld[j-1];
            n_den[j]  = r_den[j-1];
            n_side[j] = r_side[j-1];
            n_ovf[j]  = r_ovf[j-1];
            sub       = CW'(r_den[j-1]) << (Q_W - j);
            for (int k = 0; k < 3; k++) begin
                if (CW'(r_rem[j-1][k]) >= sub) begin
                    n_rem[j][k] = r_rem[j-1][k] - sub[A_W-1:0];
                    n_q[j][k]   = r_q[j-1][k] | (Q_W'(1) << (Q_W - j));
                end else begin
                    n_rem[j][k] = r_rem[j-1][k];
                    n_q[j][k]   = r_q[j-1][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STAGES; j++) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= n_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STAGES; j++) begin
            r_rem[j]  <= n_rem[j];
            r_q[j]    <= n_q[j];
            r_ovf[j]  <= n_ovf[j];
            r_den[j]  <= n_den[j];
            r_side[j] <= n_side[j];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quo   = r_q[STAGES-1];
    assign o_ovf   = r_ovf[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

### rtl/core/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to a quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine matrix elements and raise start; a transaction is taken
//   at every clock edge with start high (busy is never raised, so one
//   matrix can enter every cycle).
//   Each result appears on o_quat_* and o_clipped for exactly one cycle
//   with o_valid high; the receiver cannot stall, results are in order.
//   Pipeline (SW = square-root result bits): two stages form the branch and
//   the radicand, SW stages of the square-root pipeline give one root bit
//   each, one stage checks quotient range, FRAC_BITS + 1 divider stages give
//   one quotient bit each, and an output stage clamps and orders the
//   components.
//   Throughput is one transaction per cycle.
//   o_clipped flags a clamped component or a zero divisor.
//   Reset (synchronous, active low) drops all transactions in flight;
//   no output strobe follows until new transactions are taken.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m00,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m01,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m02,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m10,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m11,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m12,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m20,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m21,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m22,
    output logic                              o_valid,
    output logic signed [rmq_pkg::IN_W-1:0]   o_quat_w,
    output logic signed [rmq_pkg::IN_W-1:0]   o_quat_x,
    output logic signed [rmq_pkg::IN_W-1:0]   o_quat_y,
    output logic signed [rmq_pkg::IN_W-1:0]   o_quat_z,
    output logic                              o_clipped
);

    import rmq_pkg::*;

    localparam int RBW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int RS     = RBW + 1;
    localparam int SW     = (RBW + FRAC_BITS + 1) / 2;
    localparam int XW     = 2 * SW;
    localparam int C_W    = SW - 1;
    localparam int D_W    = C_W + 2;
    localparam int A_W    = MAG_W + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int LIM    = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
    localparam int LAT    = 5 + SW + FRAC_BITS;
    localparam logic signed [RS-1:0]   ONE_R = RS'(1) << FRAC_BITS;
    localparam logic signed [IN_W-1:0] LIM_S = IN_W'(LIM);

    typedef struct packed {
        t_branch        sel;
        logic           cz;
        logic [C_W-1:0] c;
        logic [2:0]     neg;
    } t_dv_side;

    assign busy = 1'b0;

    // ---------------- stage 0: diagonal combinations, off-diagonal terms
    logic                  r_s0_vld;
    logic signed [T_W-1:0] r_tr, r_t1, r_t2, r_t3;
    logic signed [N_W-1:0] r_d21_12, r_d02_20, r_d10_01;
    logic signed [N_W-1:0] r_s10_01, r_s20_02, r_s21_12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tr     <= T_W'(i_m00) + T_W'(i_m11) + T_W'(i_m22);
        r_t1     <= T_W'(i_m00) - T_W'(i_m11) - T_W'(i_m22);
        r_t2     <= T_W'(i_m11) - T_W'(i_m00) - T_W'(i_m22);
        r_t3     <= T_W'(i_m22) - T_W'(i_m00) - T_W'(i_m11);
        r_d21_12 <= N_W'(i_m21) - N_W'(i_m12);
        r_d02_20 <= N_W'(i_m02) - N_W'(i_m20);
        r_d10_01 <= N_W'(i_m10) - N_W'(i_m01);
        r_s10_01 <= N_W'(i_m10) + N_W'(i_m01);
        r_s20_02 <= N_W'(i_m20) + N_W'(i_m02);
        r_s21_12 <= N_W'(i_m21) + N_W'(i_m12);
    end

    // ---------------- stage 1: branch choice and radicand
    t_branch               n_sel;
    logic signed [T_W-1:0] n_tsel;
    logic signed [RS-1:0]  n_r;
    logic [XW-1:0]         n_rad;
    t_sq_side              n_sq_side;

    always_comb begin
        // ties fall through to the z branch
        if (r_tr > 0) begin
            n_sel  = BR_W;
            n_tsel = r_tr;
        end else if (r_t1 > r_t2 && r_t1 > r_t3) begin
            n_sel  = BR_X;
            n_tsel = r_t1;
        end else if (r_t2 > r_t1 && r_t2 > r_t3) begin
            n_sel  = BR_Y;
            n_tsel = r_t2;
        end else begin
            n_sel  = BR_Z;
            n_tsel = r_t3;
        end

        n_r = RS'(n_tsel) + ONE_R;
        if (n_r < 0) begin
            n_rad = '0;
        end else begin
            n_rad = XW'(n_r[RBW-1:0]) << FRAC_BITS;
        end

        n_sq_side.sel = n_sel;
        case (n_sel)
            BR_W: begin
                n_sq_side.n0 = r_d21_12;
                n_sq_side.n1 = r_d02_20;
                n_sq_side.n2 = r_d10_01;
            end
            BR_X: begin
                n_sq_side.n0 = r_d21_12;
                n_sq_side.n1 = r_s10_01;
                n_sq_side.n2 = r_s20_02;
            end
            BR_Y: begin
                n_sq_side.n0 = r_d02_20;
                n_sq_side.n1 = r_s10_01;
                n_sq_side.n2 = r_s21_12;
            end
            default: begin
                n_sq_side.n0 = r_d10_01;
                n_sq_side.n1 = r_s20_02;
                n_sq_side.n2 = r_s21_12;
            end
        endcase
    end

    logic          r_s1_vld;
    logic [XW-1:0] r_s1_rad;
    t_sq_side      r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_rad  <= n_rad;
        r_s1_side <= n_sq_side;
    end

    // ---------------- square root
    logic                     sq_vld;
    logic [SW-1:0]            sq_root;
    logic [$bits(t_sq_side)-1:0] sq_side_bits;
    t_sq_side                 sq_side;

    rmq_isqrt_pipe #(
        .RAD_W  (XW),
        .SIDE_W ($bits(t_sq_side))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .i_rad   (r_s1_rad),
        .i_side  (r_s1_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    assign sq_side = t_sq_side'(sq_side_bits);

    // ---------------- divider feed: magnitudes and divisor 4c
    logic [C_W-1:0]        c_val;
    logic [D_W-1:0]        den;
    logic [2:0][A_W-1:0]   num;
    logic signed [N_W-1:0] nsel [3];
    logic [N_W-1:0]        mag  [3];
    t_dv_side              dv_in_side;

    always_comb begin
        c_val   = sq_root[SW-1:1];
        den     = {c_val, 2'b00};
        nsel[0] = sq_side.n0;
        nsel[1] = sq_side.n1;
        nsel[2] = sq_side.n2;
        for (int k = 0; k < 3; k++) begin
            dv_in_side.neg[k] = nsel[k][N_W-1];
            mag[k] = nsel[k][N_W-1] ? N_W'(-nsel[k]) : N_W'(nsel[k]);
            num[k] = A_W'(mag[k][MAG_W-1:0]) << FRAC_BITS;
        end
        dv_in_side.sel = sq_side.sel;
        dv_in_side.cz  = (c_val == '0);
        dv_in_side.c   = c_val;
    end

    logic                     dv_vld;
    logic [2:0][Q_W-1:0]      dv_quo;
    logic [2:0]               dv_ovf;
    logic [$bits(t_dv_side)-1:0] dv_side_bits;
    t_dv_side                 dv_side;

    rmq_div3_pipe #(
        .A_W    (A_W),
        .D_W    (D_W),
        .Q_W    (Q_W),
        .SIDE_W ($bits(t_dv_side))
    ) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_num   (num),
        .i_den   (den),
        .i_side  (dv_in_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side_bits)
    );

    assign dv_side = t_dv_side'(dv_side_bits);

    // ---------------- output stage: clamp and place components
    logic signed [IN_W-1:0] lane [3];
    logic signed [IN_W-1:0] c_out;
    logic [IN_W-1:0]        q_abs;
    logic                   n_clip;
    logic signed [IN_W-1:0] n_w, n_x, n_y, n_z;

    always_comb begin
        n_clip = 1'b0;
        if (dv_side.c > C_W'(LIM)) begin
            c_out  = LIM_S;
            n_clip = 1'b1;
        end else begin
            c_out = IN_W'(dv_side.c);
        end
        for (int k = 0; k < 3; k++) begin
            if (dv_side.cz) begin
                q_abs  = '0;
                n_clip = 1'b1;
            end else if (dv_ovf[k] || dv_quo[k] > Q_W'(LIM)) begin
                q_abs  = LIM_S;
                n_clip = 1'b1;
            end else begin
                q_abs = IN_W'(dv_quo[k]);
            end
            lane[k] = dv_side.neg[k] ? -$signed(q_abs) : $signed(q_abs);
        end

        case (dv_side.sel)
            BR_W: begin
                n_w = c_out;   n_x = lane[0]; n_y = lane[1]; n_z = lane[2];
            end
            BR_X: begin
                n_w = lane[0]; n_x = c_out;   n_y = lane[1]; n_z = lane[2];
            end
            BR_Y: begin
                n_w = lane[0]; n_x = lane[1]; n_y = c_out;   n_z = lane[2];
            end
            default: begin
                n_w = lane[0]; n_x = lane[1]; n_y = lane[2]; n_z = c_out;
            end
        endcase
    end

    logic                   r_out_vld;
    logic signed [IN_W-1:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;
    logic                   r_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quat_w <= n_w;
        r_quat_x <= n_x;
        r_quat_y <= n_y;
        r_quat_z <= n_z;
        r_clip   <= n_clip;
    end

    assign o_valid   = r_out_vld;
    assign o_quat_w  = r_quat_w;
    assign o_quat_x  = r_quat_x;
    assign o_quat_y  = r_quat_y;
    assign o_quat_z  = r_quat_z;
    assign o_clipped = r_clip;

    // ---------------- assertions
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("transaction did not complete after the pipeline latency");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_w <= LIM_S && o_quat_w >= -LIM_S &&
                     o_quat_x <= LIM_S && o_quat_x >= -LIM_S &&
                     o_quat_y <= LIM_S && o_quat_y >= -LIM_S &&
                     o_quat_z <= LIM_S && o_quat_z >= -LIM_S))
        else $error("component beyond saturation limit");

endmodule
